### design/jdc_pkg.sv
// ----------------------------------------------------------------------------
// jdc_pkg: shared types and constants for the joystick conditioning block
// Register map, reset values and the sequencer state encoding.
// ----------------------------------------------------------------------------
package jdc_pkg;

  localparam int unsigned CfgWidth = 7;
  localparam int unsigned RootBits = 15;

  localparam logic [1:0] REG_DEAD_ZONE     = 2'd0;
  localparam logic [1:0] REG_PULL_IN       = 2'd1;
  localparam logic [1:0] REG_MAX_MAGNITUDE = 2'd2;

  localparam logic [CfgWidth-1:0] DEAD_ZONE_RST     = 7'd8;
  localparam logic [CfgWidth-1:0] PULL_IN_RST       = 7'd6;
  localparam logic [CfgWidth-1:0] MAX_MAGNITUDE_RST = 7'd64;

  localparam logic [3:0] ROOT_MSB = 4'(RootBits - 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_SQX   = 12'b0000_0000_0010,
    S_SQY   = 12'b0000_0000_0100,
    S_SUM   = 12'b0000_0000_1000,
    S_CHK   = 12'b0000_0001_0000,
    S_PA    = 12'b0000_0010_0000,
    S_PN    = 12'b0000_0100_0000,
    S_LOADN = 12'b0000_1000_0000,
    S_TSQ   = 12'b0001_0000_0000,
    S_TMD   = 12'b0010_0000_0000,
    S_TCMP  = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_t;

endpackage

### design/joystick_deadzone_and_clamp.sv
// ----------------------------------------------------------------------------
// joystick_deadzone_and_clamp: analog stick dead zone and radial clamp
// Conditions one controller poll per item: dead zone, pull-in, vector length
// limit in Q8.8, plus held and newly pressed button words.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall stays high until its result is loaded
// into the output register. A disconnected poll goes straight to the finish
// step. One shared 30x16 multiplier serves the axis squares, the limit square,
// the scaled axis products and a bit-serial 15-bit root search: each result
// bit takes a trial square, a multiply by the divisor and a compare, once for
// the length or once per axis when clamping. The output register lets the
// next item be accepted while a result waits on out_stall.
module joystick_deadzone_and_clamp
  import jdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [7:0]  raw_x,
  input  logic signed [7:0]  raw_y,
  input  logic [15:0]        buttons,
  input  logic               connected,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] stick_x,
  output logic signed [15:0] stick_y,
  output logic [14:0]        magnitude,
  output logic [15:0]        held,
  output logic [15:0]        pressed,
  output logic signed [7:0]  raw_x_out,
  output logic signed [7:0]  raw_y_out
);

  state_t state, state_next;

  logic [CfgWidth-1:0] dead_zone, pull_in, max_magnitude;
  logic [15:0]         prev_buttons;

  logic [7:0]          rx, ry, ax, ay;
  logic [15:0]         btn, pressed_r;
  logic                conn, clamp, axis;
  logic [15:0]         s;
  logic [45:0]         prod;
  logic [43:0]         n_val;
  logic [RootBits-1:0] q, qx, t, q_fin;
  logic [3:0]          bitidx;

  logic [29:0]         op_a;
  logic [15:0]         op_b;
  logic [45:0]         mul;
  logic [7:0]          ax_abs, ay_abs, cur_abs;
  logic [15:0]         dval;
  logic                cmp_ok, lim_over, accept, cfg_wr, out_load;
  logic signed [8:0]   cx9, cy9;

  function automatic logic signed [8:0] cond_axis(
    input logic signed [8:0] r,
    input logic signed [8:0] dz,
    input logic signed [8:0] pl
  );
    logic signed [8:0] res;
    if (r >= dz) begin
      res = r - pl;
    end else if (r <= -dz) begin
      res = r + pl;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    unique case (paddr[3:2])
      REG_DEAD_ZONE:     prdata = {25'b0, dead_zone};
      REG_PULL_IN:       prdata = {25'b0, pull_in};
      REG_MAX_MAGNITUDE: prdata = {25'b0, max_magnitude};
      default:           prdata = '0;
    endcase
  end

  assign cx9 = cond_axis({raw_x[7], raw_x}, {2'b0, dead_zone}, {2'b0, pull_in});
  assign cy9 = cond_axis({raw_y[7], raw_y}, {2'b0, dead_zone}, {2'b0, pull_in});

  assign ax_abs  = ax[7] ? (~ax + 8'd1) : ax;
  assign ay_abs  = ay[7] ? (~ay + 8'd1) : ay;
  assign cur_abs = axis ? ay_abs : ax_abs;
  assign dval    = clamp ? s : 16'd1;
  assign t       = q | (RootBits'(1) << bitidx);
  assign cmp_ok  = prod <= {2'b0, n_val};
  assign q_fin   = cmp_ok ? t : q;
  assign lim_over = s > {2'b0, prod[13:0]};

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_SQX: begin
        op_a = {22'b0, ax_abs};
        op_b = {8'b0, ax_abs};
      end
      S_SQY: begin
        op_a = {22'b0, ay_abs};
        op_b = {8'b0, ay_abs};
      end
      S_SUM: begin
        op_a = {23'b0, max_magnitude};
        op_b = {9'b0, max_magnitude};
      end
      S_PA: begin
        op_a = {22'b0, cur_abs};
        op_b = {9'b0, max_magnitude};
      end
      S_PN: begin
        op_a = {15'b0, prod[14:0]};
        op_b = {1'b0, prod[14:0]};
      end
      S_TSQ: begin
        op_a = {15'b0, t};
        op_b = {1'b0, t};
      end
      S_TMD: begin
        op_a = prod[29:0];
        op_b = dval;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul = {16'b0, op_a} * {30'b0, op_b};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) begin
        state_next = connected ? S_SQX : S_FIN;
      end
      S_SQX:   state_next = S_SQY;
      S_SQY:   state_next = S_SUM;
      S_SUM:   state_next = S_CHK;
      S_CHK:   state_next = lim_over ? S_PA : S_TSQ;
      S_PA:    state_next = S_PN;
      S_PN:    state_next = S_LOADN;
      S_LOADN: state_next = S_TSQ;
      S_TSQ:   state_next = S_TMD;
      S_TMD:   state_next = S_TCMP;
      S_TCMP: begin
        if (bitidx != 4'd0) begin
          state_next = S_TSQ;
        end else if (clamp && !axis) begin
          state_next = S_PA;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN:   if (out_load) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      prev_buttons  <= '0;
      dead_zone     <= DEAD_ZONE_RST;
      pull_in       <= PULL_IN_RST;
      max_magnitude <= MAX_MAGNITUDE_RST;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        prev_buttons <= connected ? buttons : 16'd0;
      end
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_DEAD_ZONE:     dead_zone     <= pwdata[CfgWidth-1:0];
          REG_PULL_IN:       pull_in       <= pwdata[CfgWidth-1:0];
          REG_MAX_MAGNITUDE: max_magnitude <= pwdata[CfgWidth-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (accept) begin
        rx        <= raw_x;
        ry        <= raw_y;
        ax        <= cx9[7:0];
        ay        <= cy9[7:0];
        btn       <= buttons;
        conn      <= connected;
        pressed_r <= buttons & ~prev_buttons;
      end
      S_SQX: prod <= mul;
      S_SQY: begin
        s    <= prod[15:0];
        prod <= mul;
      end
      S_SUM: begin
        s    <= s + prod[15:0];
        prod <= mul;
      end
      S_CHK: begin
        clamp  <= lim_over;
        axis   <= 1'b0;
        n_val  <= {12'b0, s, 16'b0};
        q      <= '0;
        bitidx <= ROOT_MSB;
      end
      S_PA: prod <= mul;
      S_PN: prod <= mul;
      S_LOADN: begin
        n_val  <= {prod[27:0], 16'b0};
        q      <= '0;
        bitidx <= ROOT_MSB;
      end
      S_TSQ: prod <= mul;
      S_TMD: prod <= mul;
      S_TCMP: begin
        q <= q_fin;
        if (bitidx != 4'd0) begin
          bitidx <= bitidx - 4'd1;
        end else if (clamp && !axis) begin
          qx   <= q_fin;
          axis <= 1'b1;
        end
      end
      S_FIN: if (out_load) begin
        if (!conn) begin
          stick_x   <= '0;
          stick_y   <= '0;
          magnitude <= '0;
          held      <= '0;
          pressed   <= '0;
          raw_x_out <= '0;
          raw_y_out <= '0;
        end else begin
          if (clamp) begin
            stick_x   <= ax[7] ? (~{1'b0, qx} + 16'd1) : {1'b0, qx};
            stick_y   <= ay[7] ? (~{1'b0, q} + 16'd1) : {1'b0, q};
            magnitude <= {max_magnitude, 8'b0};
          end else begin
            stick_x   <= {ax, 8'b0};
            stick_y   <= {ay, 8'b0};
            magnitude <= q;
          end
          held      <= btn;
          pressed   <= pressed_r;
          raw_x_out <= rx;
          raw_y_out <= ry;
        end
      end
      default: ;
    endcase
  end

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result appeared without a finish step");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("block did not go busy after taking an item");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_TCMP && clamp && cmp_ok) |-> (t <= {max_magnitude, 8'b0}))
    else $error("scaled axis exceeds the length limit");

  a_root_loop: assert property (@(posedge clk) disable iff (rst)
    (state == S_TCMP && bitidx != 4'd0) |=> (state == S_TSQ))
    else $error("root search left before its last bit");

endmodule

### tb/stick_conditioning_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stick_conditioning_checker: result predictor and comparator
// Tracks register writes on the APB port, predicts each conditioned poll
// (dead zone, pull-in, radial clamp, button edges) and compares every result
// taken from the output channel against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module stick_conditioning_checker
  import jdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  raw_x,
  input  logic [7:0]  raw_y,
  input  logic [15:0] buttons,
  input  logic        connected,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] stick_x,
  input  logic [15:0] stick_y,
  input  logic [14:0] magnitude,
  input  logic [15:0] held,
  input  logic [15:0] pressed,
  input  logic [7:0]  raw_x_out,
  input  logic [7:0]  raw_y_out,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic [14:0] mag;
    logic [15:0] held;
    logic [15:0] pressed;
    logic [7:0]  rxo;
    logic [7:0]  ryo;
  } poll_out_t;

  logic [CfgWidth-1:0] dz_cfg;
  logic [CfgWidth-1:0] pull_cfg;
  logic [CfgWidth-1:0] lim_cfg;
  logic [15:0]         last_buttons;
  poll_out_t           expected_polls[$];

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 24; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic int pull_axis(input int raw);
    int dz, pl;
    dz = dz_cfg;
    pl = pull_cfg;
    if (raw >= dz) return raw - pl;
    if (raw <= -dz) return raw + pl;
    return 0;
  endfunction

  // floor(|a| * lim * 256 / sqrt(sq)), exact via integer root of the quotient
  function automatic int clamp_axis(input int a, input longint unsigned sq,
                                    input longint unsigned lim);
    longint unsigned m, n, q;
    m = (a < 0) ? -a : a;
    n = m * lim * 256;
    q = floor_root((n * n) / sq);
    return (a < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic poll_out_t condition_poll(input logic [7:0] rx, input logic [7:0] ry,
                                               input logic [15:0] btn, input logic conn);
    poll_out_t r;
    int ax, ay;
    longint unsigned sq, lim;
    r = '0;
    if (!conn) return r;
    ax = pull_axis($signed(rx));
    ay = pull_axis($signed(ry));
    sq = ax * ax + ay * ay;
    lim = lim_cfg;
    if (sq > lim * lim) begin
      r.sx  = 16'(clamp_axis(ax, sq, lim));
      r.sy  = 16'(clamp_axis(ay, sq, lim));
      r.mag = 15'(lim * 256);
    end else begin
      r.sx  = 16'(ax * 256);
      r.sy  = 16'(ay * 256);
      r.mag = 15'(floor_root(sq << 16));
    end
    r.held    = btn;
    r.pressed = btn & ~last_buttons;
    r.rxo     = rx;
    r.ryo     = ry;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected 'h%0h got 'h%0h", $time, fname, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    poll_out_t want;
    if (rst) begin
      dz_cfg       <= DEAD_ZONE_RST;
      pull_cfg     <= PULL_IN_RST;
      lim_cfg      <= MAX_MAGNITUDE_RST;
      last_buttons <= '0;
      expected_polls.delete();
      outstanding  <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_DEAD_ZONE:     dz_cfg   <= pwdata[CfgWidth-1:0];
          REG_PULL_IN:       pull_cfg <= pwdata[CfgWidth-1:0];
          REG_MAX_MAGNITUDE: lim_cfg  <= pwdata[CfgWidth-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_polls.size() == 0) begin
          mismatches++;
          $display("%0t: result with no item pending", $time);
        end else begin
          want = expected_polls.pop_front();
          check_field("stick_x", want.sx, stick_x);
          check_field("stick_y", want.sy, stick_y);
          check_field("magnitude", 16'(want.mag), 16'(magnitude));
          check_field("held", want.held, held);
          check_field("pressed", want.pressed, pressed);
          check_field("raw_x_out", 16'(want.rxo), 16'(raw_x_out));
          check_field("raw_y_out", 16'(want.ryo), 16'(raw_y_out));
        end
      end
      if (in_valid && !in_stall) begin
        expected_polls.push_back(condition_poll(raw_x, raw_y, buttons, connected));
        last_buttons <= connected ? buttons : 16'h0000;
      end
      outstanding <= expected_polls.size();
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: joystick_deadzone_and_clamp testbench
// Directed polls for the dead zone edges, pull-in across zero, clamping and
// disconnect, then random polls over several register settings with random
// idling on both channels, one back-pressure stretch and one gap-free phase.
// ----------------------------------------------------------------------------
module tb_top;
  import jdc_pkg::*;

  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 240;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic signed [7:0] raw_x = '0;
  logic signed [7:0] raw_y = '0;
  logic [15:0] buttons = '0;
  logic        connected = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [15:0] stick_x;
  logic signed [15:0] stick_y;
  logic [14:0] magnitude;
  logic [15:0] held;
  logic [15:0] pressed;
  logic signed [7:0] raw_x_out;
  logic signed [7:0] raw_y_out;

  int   mismatches;
  int   outstanding;
  bit   steady = 1'b0;
  bit   hold_req = 1'b0;
  int   cur_dz = DEAD_ZONE_RST;
  logic [15:0] last_btn = '0;

  int dz_set[8]   = '{8, 0, 127, 20, 3, 127, 0, -1};
  int pull_set[8] = '{6, 0, 127, 40, 10, 0, 127, -1};
  int lim_set[8]  = '{64, 127, 1, 30, 0, 127, 1, -1};

  joystick_deadzone_and_clamp u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .raw_x, .raw_y, .buttons, .connected,
    .out_valid, .out_stall, .stick_x, .stick_y, .magnitude, .held, .pressed,
    .raw_x_out, .raw_y_out
  );

  stick_conditioning_checker u_check (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_stall, .raw_x, .raw_y, .buttons, .connected,
    .out_valid, .out_stall, .stick_x, .stick_y, .magnitude, .held, .pressed,
    .raw_x_out, .raw_y_out, .mismatches, .outstanding
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin : watchdog
    #40_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // receiver side: random stall, plus one long hold-off on request
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 36);
      end
    end
  end

  task automatic send_poll(input int x, input int y, input logic [15:0] btn,
                           input logic conn);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    raw_x     <= 8'(x);
    raw_y     <= 8'(y);
    buttons   <= btn;
    connected <= conn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    logic [31:0] noise;
    noise = $urandom;
    if (idx == REG_DEAD_ZONE) cur_dz = value & 7'h7f;
    paddr   <= {idx, 2'b00};
    pwdata  <= {noise[31:7], 7'(value)};
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(input int count);
    for (int k = 0; k < count; k++) begin
      int x, y;
      logic [15:0] b;
      x = $signed(8'($urandom));
      y = $signed(8'($urandom));
      // aim at the dead zone edges now and then
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(3))
          0: x = cur_dz;
          1: x = cur_dz - 1;
          2: x = -cur_dz;
          default: x = 1 - cur_dz;
        endcase
      end
      if ($urandom_range(4) == 0) y = ($urandom_range(1) != 0) ? cur_dz : -cur_dz;
      if ($urandom_range(1) != 0) b = 16'($urandom);
      else b = last_btn ^ (16'h0001 << $urandom_range(15));
      last_btn = b;
      send_poll(x, y, b, $urandom_range(9) != 0);
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: dead zone edges, clamp, buttons, disconnect
    send_poll(0, 0, 16'h0000, 1'b1);
    send_poll(7, -7, 16'hFFFF, 1'b1);
    send_poll(8, -8, 16'hA5A5, 1'b1);
    send_poll(-8, 8, 16'h5A5A, 1'b1);
    send_poll(127, 0, 16'hFFFF, 1'b1);
    send_poll(-128, -128, 16'h0001, 1'b1);
    send_poll(127, 127, 16'h8000, 1'b1);
    send_poll(-128, 127, 16'h8001, 1'b1);
    send_poll(40, 30, 16'h7FFE, 1'b1);
    send_poll(0, -128, 16'hFFFF, 1'b1);
    send_poll(-99, 55, 16'hFFFF, 1'b0);
    send_poll(-1, 1, 16'h0F0F, 1'b1);

    // zero dead zone, pull-in crossing zero
    drain_results();
    write_reg(REG_DEAD_ZONE, 0);
    write_reg(REG_PULL_IN, 10);
    write_reg(REG_MAX_MAGNITUDE, 127);
    send_poll(0, 0, 16'h1234, 1'b1);
    send_poll(8, -8, 16'h4321, 1'b1);
    send_poll(-128, -128, 16'hFFFF, 1'b1);
    send_poll(127, -1, 16'h0000, 1'b1);

    // zero length limit, unmapped register
    drain_results();
    write_reg(REG_DEAD_ZONE, 127);
    write_reg(REG_PULL_IN, 127);
    write_reg(REG_MAX_MAGNITUDE, 0);
    write_reg(REG_UNMAPPED, 5);
    send_poll(127, -127, 16'h00FF, 1'b1);
    send_poll(-128, 5, 16'hFF00, 1'b1);
    send_poll(126, -128, 16'hFFFF, 1'b1);

    drain_results();
    write_reg(REG_DEAD_ZONE, 1);
    write_reg(REG_PULL_IN, 0);
    write_reg(REG_MAX_MAGNITUDE, 1);
    send_poll(1, 1, 16'h0001, 1'b1);
    send_poll(-1, 0, 16'h0002, 1'b1);
    send_poll(0, -128, 16'h0003, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      write_reg(REG_DEAD_ZONE, dz_set[ph] < 0 ? $urandom_range(127) : dz_set[ph]);
      write_reg(REG_PULL_IN, pull_set[ph] < 0 ? $urandom_range(127) : pull_set[ph]);
      write_reg(REG_MAX_MAGNITUDE, lim_set[ph] < 0 ? $urandom_range(127) : lim_set[ph]);
      steady = (ph == 2);
      if (ph == 4) hold_req = 1'b1;
      send_random(PhaseItems);
    end

    drain_results();
    steady = 1'b0;
    repeat (150) @(posedge clk);
    if (mismatches == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
